FILE: rtl/core/psw_pkg.sv
// Shared constants and types for the port scan window detector.
`default_nettype none

package psw_pkg;

    localparam int PSW_WINDOW_DEPTH = 64;

    localparam int TS_W     = 48;
    localparam int PORT_W   = 16;
    localparam int THR_W    = 11;
    localparam int MS_W     = 32;
    localparam int SIZE_W   = 16;
    localparam int DIST_W   = 7;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [THR_W-1:0]  TCP_THR_RST   = 11'd18;
    localparam logic [THR_W-1:0]  UDP_THR_RST   = 11'd24;
    localparam logic [MS_W-1:0]   WINDOW_MS_RST = 32'd15000;
    localparam logic [MS_W-1:0]   COOLDOWN_RST  = 32'd30000;
    localparam logic [SIZE_W-1:0] PROBE_LIM_RST = 16'd96;

    // register map, word index
    localparam logic [2:0] REG_TCP_THR   = 3'd0;
    localparam logic [2:0] REG_UDP_THR   = 3'd1;
    localparam logic [2:0] REG_WINDOW_MS = 3'd2;
    localparam logic [2:0] REG_COOLDOWN  = 3'd3;
    localparam logic [2:0] REG_PROBE_LIM = 3'd4;

    localparam logic [1:0] PROTO_TCP = 2'd0;
    localparam logic [1:0] PROTO_UDP = 2'd1;
    localparam logic [1:0] DIR_IN    = 2'd0;
    localparam logic [1:0] DIR_OUT   = 2'd1;

    localparam int SYN_POS = 1;
    localparam int ACK_POS = 4;

    typedef struct packed {
        logic [THR_W-1:0]  tcp_threshold;
        logic [THR_W-1:0]  udp_threshold;
        logic [MS_W-1:0]   window_ms;
        logic [MS_W-1:0]   cooldown_ms;
        logic [SIZE_W-1:0] probe_size_limit;
    } psw_cfg_t;

    // window commands; rd and mark may be issued together during the walk
    typedef struct packed {
        logic rd;
        logic evict;
        logic append;
        logic mark;
    } psw_win_cmd_t;

    typedef struct packed {
        logic [TS_W-1:0]   rd_time;
        logic [PORT_W-1:0] rd_port;
    } psw_win_rd_t;

endpackage

`default_nettype wire

FILE: rtl/core/psw_regs.sv
// APB configuration register bank.
`default_nettype none

module psw_regs
    import psw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output psw_cfg_t               cfg
);

    psw_cfg_t   cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tcp_threshold    <= TCP_THR_RST;
            cfg_reg.udp_threshold    <= UDP_THR_RST;
            cfg_reg.window_ms        <= WINDOW_MS_RST;
            cfg_reg.cooldown_ms      <= COOLDOWN_RST;
            cfg_reg.probe_size_limit <= PROBE_LIM_RST;
        end else if (wr_en) begin
            case (idx)
                REG_TCP_THR:   cfg_reg.tcp_threshold    <= pwdata[THR_W-1:0];
                REG_UDP_THR:   cfg_reg.udp_threshold    <= pwdata[THR_W-1:0];
                REG_WINDOW_MS: cfg_reg.window_ms        <= pwdata;
                REG_COOLDOWN:  cfg_reg.cooldown_ms      <= pwdata;
                REG_PROBE_LIM: cfg_reg.probe_size_limit <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TCP_THR:   prdata = DATA_W'(cfg_reg.tcp_threshold);
            REG_UDP_THR:   prdata = DATA_W'(cfg_reg.udp_threshold);
            REG_WINDOW_MS: prdata = cfg_reg.window_ms;
            REG_COOLDOWN:  prdata = cfg_reg.cooldown_ms;
            REG_PROBE_LIM: prdata = DATA_W'(cfg_reg.probe_size_limit);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/psw_filter.sv
// Packet qualification: decides whether an item enters the window.
`default_nettype none

module psw_filter
    import psw_pkg::*;
(
    input  wire logic [TS_W-1:0]   timestamp_ms,
    input  wire logic [1:0]        protocol,
    input  wire logic [1:0]        direction,
    input  wire logic [PORT_W-1:0] local_port,
    input  wire logic [PORT_W-1:0] remote_port,
    input  wire logic              flags_valid,
    input  wire logic [7:0]        tcp_flags,
    input  wire logic [SIZE_W-1:0] payload_size,
    input  wire logic [SIZE_W-1:0] total_size,
    input  wire logic [SIZE_W-1:0] probe_size_limit,
    output logic                   hit,
    output logic                   is_udp,
    output logic [PORT_W-1:0]      port
);

    logic known;
    logic probe;

    assign known  = (timestamp_ms != '0)
                 && (direction == DIR_IN || direction == DIR_OUT)
                 && (protocol == PROTO_TCP || protocol == PROTO_UDP);
    assign is_udp = (protocol == PROTO_UDP);
    assign port   = (direction == DIR_IN) ? local_port : remote_port;

    // TCP probe: SYN without ACK, or a small empty packet when flags are unreadable
    always_comb begin
        if (flags_valid) begin
            probe = tcp_flags[SYN_POS] && !tcp_flags[ACK_POS];
        end else begin
            probe = (payload_size == '0) && (total_size <= probe_size_limit);
        end
    end

    assign hit = known && (is_udp || probe) && (port != '0);

endmodule

`default_nettype wire

FILE: rtl/core/psw_window.sv
// Ring buffer of (time, port) entries with last-occurrence flags and distinct count.
`default_nettype none

module psw_window
    import psw_pkg::*;
#(
    parameter int DEPTH = PSW_WINDOW_DEPTH,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire psw_win_cmd_t      cmd,
    input  wire logic [IW-1:0]     rd_off,
    input  wire logic [IW-1:0]     mark_off,
    input  wire logic [TS_W-1:0]   app_time,
    input  wire logic [PORT_W-1:0] app_port,
    output logic      [CW-1:0]     count,
    output logic      [CW-1:0]     distinct,
    output psw_win_rd_t            rd_data
);

    logic [TS_W-1:0]   time_mem [DEPTH];
    logic [PORT_W-1:0] port_mem [DEPTH];
    // set when a younger entry holds the same port
    logic [DEPTH-1:0]  dup_reg;

    logic [IW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] dist_reg, dist_next;
    psw_win_rd_t   rd_reg;

    logic [IW-1:0] rd_slot, mark_slot, app_slot;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign rd_slot   = slot_of(oldest_reg, rd_off);
    assign mark_slot = slot_of(oldest_reg, mark_off);
    assign app_slot  = slot_of(oldest_reg, count_reg[IW-1:0]);

    assign count    = count_reg;
    assign distinct = dist_reg;
    assign rd_data  = rd_reg;

    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        dist_next   = dist_reg;
        if (cmd.evict) begin
            oldest_next = (oldest_reg == IW'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
            count_next  = count_reg - 1'b1;
            if (!dup_reg[oldest_reg]) begin
                dist_next = dist_reg - 1'b1;
            end
        end else if (cmd.append) begin
            count_next = count_reg + 1'b1;
            dist_next  = dist_reg + 1'b1;
        end else if (cmd.mark && !dup_reg[mark_slot]) begin
            dist_next = dist_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
            dist_reg   <= '0;
        end else begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            dist_reg   <= dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            dup_reg[app_slot] <= 1'b0;
        end else if (cmd.mark) begin
            dup_reg[mark_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            time_mem[app_slot] <= app_time;
            port_mem[app_slot] <= app_port;
        end
        if (cmd.rd) begin
            rd_reg.rd_time <= time_mem[rd_slot];
            rd_reg.rd_port <= port_mem[rd_slot];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/port_scan_window_detector.sv
// Top level of the port scan window detector: sequencer, shared time unit, result register.
//
// Watches one scan key for port scans. Each item is a packet summary; items
// with a zero timestamp, unknown direction, a protocol other than TCP/UDP, a
// TCP packet that is not a probe, or a probe port of zero are dropped
// while the block stays idle. A counted item is appended to a ring of
// WINDOW_DEPTH (time, port) entries (the oldest is dropped when full),
// entries older than window_ms are evicted from the oldest end, and when
// the distinct port count reaches the TCP or UDP threshold outside the
// cooldown one alert item is issued. Each stored entry carries a flag that
// marks it as superseded by a younger entry with the same port, so the
// distinct count is kept as a running total: a new port is compared against
// every stored entry once, through the single read port of the port memory.
// A counted item is compared against the entries held before it (one less
// when the ring was full), is appended and then evicts the expired entries;
// its alert may wait for the result register. One 48-bit subtract/compare
// unit serves both the eviction age test and the cooldown test. s_ready is
// high only between items. A waiting result does not block the next item;
// only a new alert waits for the result register to empty.
// Configuration goes through a small APB port with registers at byte
// addresses 0x00 tcp_threshold, 0x04 udp_threshold, 0x08 window_ms,
// 0x0C cooldown_ms, 0x10 probe_size_limit; write it only while idle.
`default_nettype none

module port_scan_window_detector
    import psw_pkg::*;
#(
    parameter int WINDOW_DEPTH = PSW_WINDOW_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [TS_W-1:0]   s_timestamp_ms,
    input  wire logic [1:0]        s_protocol,
    input  wire logic [1:0]        s_direction,
    input  wire logic [PORT_W-1:0] s_local_port,
    input  wire logic [PORT_W-1:0] s_remote_port,
    input  wire logic              s_flags_valid,
    input  wire logic [7:0]        s_tcp_flags,
    input  wire logic [SIZE_W-1:0] s_payload_size,
    input  wire logic [SIZE_W-1:0] s_total_size,
    // alert items
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_rule_is_udp,
    output logic [DIST_W-1:0]      m_distinct_ports,
    output logic [TS_W-1:0]        m_alert_time_ms,
    output logic [PORT_W-1:0]      m_probe_port,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = (CW > THR_W) ? CW : THR_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,    // drop the oldest entry when the ring is full
        ST_WALK,    // compare new port against every stored entry
        ST_APPEND,
        ST_EV_RD,   // read oldest entry time
        ST_EV_CHK,  // age test, evict and loop
        ST_DECIDE   // threshold and cooldown, load result
    } state_t;

    psw_cfg_t cfg;

    logic              flt_hit;
    logic              flt_udp;
    logic [PORT_W-1:0] flt_port;

    psw_win_cmd_t  cmd;
    logic [IW-1:0] rd_off;
    logic [IW-1:0] mark_off;
    logic [CW-1:0] win_count;
    logic [CW-1:0] win_dist;
    psw_win_rd_t   win_rd;

    state_t            state_reg, state_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              udp_reg, udp_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]     cmp_off_reg, cmp_off_next;
    logic [TS_W-1:0]   last_alert_reg, last_alert_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_udp_reg, m_udp_next;
    logic [DIST_W-1:0] m_dist_reg, m_dist_next;
    logic [TS_W-1:0]   m_time_reg, m_time_next;
    logic [PORT_W-1:0] m_port_reg, m_port_next;

    // shared time unit: age of the oldest entry, or time since last alert
    logic [TS_W-1:0] tu_b;
    logic [TS_W-1:0] tu_lim;
    logic [TS_W-1:0] tu_diff;
    logic            tu_gt;
    logic            expired;
    logic            cool_block;

    logic [TW-1:0]     dist_w;
    logic [TW-1:0]     thr_w;
    logic [DIST_W-1:0] dist_sat;
    logic              issue;

    psw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psw_filter u_filter (
        .timestamp_ms     (s_timestamp_ms),
        .protocol         (s_protocol),
        .direction        (s_direction),
        .local_port       (s_local_port),
        .remote_port      (s_remote_port),
        .flags_valid      (s_flags_valid),
        .tcp_flags        (s_tcp_flags),
        .payload_size     (s_payload_size),
        .total_size       (s_total_size),
        .probe_size_limit (cfg.probe_size_limit),
        .hit              (flt_hit),
        .is_udp           (flt_udp),
        .port             (flt_port)
    );

    psw_window #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_off   (rd_off),
        .mark_off (mark_off),
        .app_time (ts_reg),
        .app_port (port_reg),
        .count    (win_count),
        .distinct (win_dist),
        .rd_data  (win_rd)
    );

    assign tu_b     = (state_reg == ST_EV_CHK) ? win_rd.rd_time : last_alert_reg;
    assign tu_lim   = (state_reg == ST_EV_CHK) ? TS_W'(cfg.window_ms)
                                               : TS_W'(cfg.cooldown_ms);
    assign tu_gt    = ts_reg > tu_b;
    assign tu_diff  = ts_reg - tu_b;
    assign expired  = tu_gt && (tu_diff > tu_lim);
    // time running backwards never blocks an alert
    assign cool_block = (last_alert_reg != '0) && tu_gt && (tu_diff < tu_lim);

    assign dist_w   = TW'(win_dist);
    assign thr_w    = TW'(udp_reg ? cfg.udp_threshold : cfg.tcp_threshold);
    assign dist_sat = (dist_w > TW'(127)) ? 7'd127 : DIST_W'(win_dist);

    assign issue = (iss_reg < win_count);

    always_comb begin
        state_next      = state_reg;
        ts_next         = ts_reg;
        port_next       = port_reg;
        udp_next        = udp_reg;
        iss_next        = iss_reg;
        cmp_vld_next    = 1'b0;
        cmp_off_next    = cmp_off_reg;
        last_alert_next = last_alert_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_udp_next      = m_udp_reg;
        m_dist_next     = m_dist_reg;
        m_time_next     = m_time_reg;
        m_port_next     = m_port_reg;
        cmd             = '0;
        rd_off          = '0;
        mark_off        = cmp_off_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ts_next   = s_timestamp_ms;
                    port_next = flt_port;
                    udp_next  = flt_udp;
                    if (flt_hit) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (win_count == CW'(WINDOW_DEPTH)) begin
                    cmd.evict = 1'b1;
                end
                iss_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // read entry iss, compare the one read last cycle
                if (issue) begin
                    cmd.rd       = 1'b1;
                    rd_off       = iss_reg[IW-1:0];
                    iss_next     = iss_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_off_next = iss_reg[IW-1:0];
                end else begin
                    state_next = ST_APPEND;
                end
                if (cmp_vld_reg && (win_rd.rd_port == port_reg)) begin
                    cmd.mark = 1'b1;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_EV_RD;
            end
            ST_EV_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_EV_CHK;
            end
            ST_EV_CHK: begin
                // the new entry is never older than itself, so the loop ends
                if (expired) begin
                    cmd.evict  = 1'b1;
                    state_next = ST_EV_RD;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((dist_w < thr_w) || cool_block) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    last_alert_next = ts_reg;
                    m_valid_next    = 1'b1;
                    m_udp_next      = udp_reg;
                    m_dist_next     = dist_sat;
                    m_time_next     = ts_reg;
                    m_port_next     = port_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            iss_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            last_alert_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            iss_reg        <= iss_next;
            cmp_vld_reg    <= cmp_vld_next;
            last_alert_reg <= last_alert_next;
            m_valid_reg    <= m_valid_next;
            ts_reg         <= ts_next;
            port_reg       <= port_next;
            udp_reg        <= udp_next;
            cmp_off_reg    <= cmp_off_next;
            m_udp_reg      <= m_udp_next;
            m_dist_reg     <= m_dist_next;
            m_time_reg     <= m_time_next;
            m_port_reg     <= m_port_next;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_rule_is_udp    = m_udp_reg;
    assign m_distinct_ports = m_dist_reg;
    assign m_alert_time_ms  = m_time_reg;
    assign m_probe_port     = m_port_reg;

endmodule

`default_nettype wire

FILE: rtl/core/psw_checker.sv
// Port-level assertions for the port scan window detector, bound to the top level.
`default_nettype none

module psw_checker
    import psw_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic [TS_W-1:0]   s_timestamp_ms,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_rule_is_udp,
    input wire logic [DIST_W-1:0] m_distinct_ports,
    input wire logic [TS_W-1:0]   m_alert_time_ms,
    input wire logic [PORT_W-1:0] m_probe_port
);

    // a stalled alert item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rule_is_udp)
            && $stable(m_distinct_ports) && $stable(m_alert_time_ms)
            && $stable(m_probe_port))
        else $error("alert item changed while stalled");

    // an item with unknown time is dropped at once
    a_zero_ts_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_timestamp_ms == '0) |=> s_ready)
        else $error("zero-timestamp item kept the block busy");

    // alerts only come from counted packets
    a_alert_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_probe_port != '0) && (m_alert_time_ms != '0)
            && (m_distinct_ports != '0))
        else $error("alert with zero port, time or count");

    // a new alert is produced only while an item is being worked on
    a_alert_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("alert raised while idle");

endmodule

bind port_scan_window_detector psw_checker u_psw_checker (.*);

`default_nettype wire
